// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, switched off while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/rmc_pkg.sv =====
`default_nettype none

package rmc_pkg;

  // Default memory depth in words; it must be a power of two.
  localparam int unsigned MEM_DEPTH_DEF = 4096;

  // Registers with a fixed role.
  localparam logic [3:0] R_DS = 4'd0;
  localparam logic [3:0] R_IP = 4'd5;
  localparam logic [3:0] R_CC = 4'd8;
  localparam logic [3:0] R_AC = 4'd9;

  localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

  // Host function codes.
  localparam logic [2:0] FUNC_WMEM = 3'd0;
  localparam logic [2:0] FUNC_WREG = 3'd1;
  localparam logic [2:0] FUNC_STEP = 3'd2;
  localparam logic [2:0] FUNC_RMEM = 3'd3;
  localparam logic [2:0] FUNC_RREG = 3'd4;

  // Operand types.
  localparam logic [1:0] T_IMM = 2'd0;
  localparam logic [1:0] T_REG = 2'd1;
  localparam logic [1:0] T_DIR = 2'd2;

  // Register sectors.
  localparam logic [1:0] SEC_WORD = 2'd0;
  localparam logic [1:0] SEC_B0   = 2'd1;
  localparam logic [1:0] SEC_B1   = 2'd2;
  localparam logic [1:0] SEC_HALF = 2'd3;

  // Two-operand opcodes.
  localparam logic [3:0] OP_MOV  = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_SUB  = 4'd2;
  localparam logic [3:0] OP_SWAP = 4'd3;
  localparam logic [3:0] OP_MUL  = 4'd4;
  localparam logic [3:0] OP_DIV  = 4'd5;
  localparam logic [3:0] OP_CMP  = 4'd6;
  localparam logic [3:0] OP_SHL  = 4'd7;
  localparam logic [3:0] OP_SHR  = 4'd8;
  localparam logic [3:0] OP_AND  = 4'd9;
  localparam logic [3:0] OP_OR   = 4'd10;
  localparam logic [3:0] OP_XOR  = 4'd11;

  // One-operand sub-opcodes.
  localparam logic [3:0] OP1_JMP = 4'd1;
  localparam logic [3:0] OP1_JZ  = 4'd2;
  localparam logic [3:0] OP1_JP  = 4'd3;
  localparam logic [3:0] OP1_JN  = 4'd4;
  localparam logic [3:0] OP1_JNZ = 4'd5;
  localparam logic [3:0] OP1_JNP = 4'd6;
  localparam logic [3:0] OP1_JNN = 4'd7;
  localparam logic [3:0] OP1_LDL = 4'd8;
  localparam logic [3:0] OP1_LDH = 4'd9;
  localparam logic [3:0] OP1_RND = 4'd10;
  localparam logic [3:0] OP1_NOT = 4'd11;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE, S_HOST, S_HRD, S_FETCH, S_OPA, S_OPA2, S_OPB2,
    S_EXEC, S_DIV, S_WBA, S_WBB, S_DONE
  } state_e;

  // Control to and status from the divider.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Condition code for a result.
  function automatic logic [31:0] cc_of(input logic [31:0] v);
    logic [31:0] r;
    if (v == 32'd0) begin
      r = 32'd1;
    end else if (v[31]) begin
      r = SIGN_BIT;
    end else begin
      r = 32'd0;
    end
    return r;
  endfunction

  // Sector of a register as read by an operand.
  function automatic logic [31:0] rd_sector(input logic [31:0] r, input logic [1:0] sec);
    logic [31:0] v;
    case (sec)
      SEC_WORD: v = r;
      SEC_B0:   v = {24'd0, r[7:0]};
      SEC_B1:   v = {24'd0, r[15:8]};
      default:  v = {16'd0, r[15:0]};
    endcase
    return v;
  endfunction

  // Merge of a written value into one sector of a register.
  function automatic logic [31:0] wr_sector(input logic [31:0] old, input logic [31:0] v,
                                            input logic [1:0] sec);
    logic [31:0] r;
    case (sec)
      SEC_WORD: r = v;
      SEC_B0:   r = {old[31:8], v[7:0]};
      SEC_B1:   r = {old[31:16], v[7:0], old[7:0]};
      default:  r = {old[31:16], v[15:0]};
    endcase
    return r;
  endfunction

  // Sign extension of the second operand of a two-operand instruction.
  function automatic logic [31:0] ext_b(input logic [31:0] v, input logic [1:0] t,
                                        input logic [1:0] sec);
    logic [31:0] r;
    r = v;
    if (t == T_IMM) begin
      r = {{20{v[11]}}, v[11:0]};
    end else if (t == T_REG && (sec == SEC_B0 || sec == SEC_B1)) begin
      r = {{24{v[7]}}, v[7:0]};
    end else if (t == T_REG && sec == SEC_HALF) begin
      r = {{16{v[15]}}, v[15:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rmc_ram.sv =====
`default_nettype none

// Single-port word memory with registered read data.
module rmc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read at the same address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/rmc_div.sv =====
`default_nettype none

// Unsigned 32-bit restoring divider, one quotient bit per cycle.
module rmc_div import rmc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire div_ctrl_t   ctrl_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output div_stat_t        stat_o,
  output logic [31:0]      quotient_o,
  output logic [31:0]      remainder_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [32:0] shifted;
  logic [33:0] trial;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem_q, quo_q[31]};
    trial   = {1'b0, shifted} - {2'b00, dvs_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 5'd0;
      quo_d  = dividend_i;
      rem_d  = 32'd0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial[33]) begin
        rem_d = shifted[31:0];
        quo_d = {quo_q[30:0], 1'b0};
      end else begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = quo_q;
  assign remainder_o  = rem_q;

endmodule

`default_nettype wire

// ===== rtl/register_memory_cpu_core.sv =====
`default_nettype none
// Small 32-bit register-memory core with host access over one stream channel.
// Each input word on the slave side is a host command: write or read a memory
// word, write or read a register, or execute one instruction fetched at IP.
// Each command gives exactly one result word on the master side with the read
// data, the IP afterwards, the halted flag and the divide error flag.
// The core takes one command at a time; tready is high only while it is idle.
// Host accesses pass through the idle, host and output states, a memory read
// also through a read state. An instruction passes through the host step, fetch
// and operand reads, one execute step, up to two write-back steps and the output
// step; STOP goes to the output step from its decode after the fetch, and DIV
// and RND also wait for the bit-serial divider unless the divisor is zero.
// The single memory port sets the sequence: fetch, first operand, second
// operand and each write-back use it in turn.
// Reset clears all registers, so the core starts halted; memory contents are
// undefined until the host writes them. If the receiver stalls, the result
// is held in the output register and the next command may still be taken;
// that command finishes its work and waits for the output register.
// MEM_DEPTH must be a power of two; addresses are taken modulo the depth.
`include "assert_macros.svh"

module register_memory_cpu_core import rmc_pkg::*; #(
  parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // func[2:0], mem_address[14:3], reg_index[18:15], write_word[50:19],
  // random_value[81:51], zero fill up to 88 bits
  input  wire logic [87:0] s_axis_tdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // read_data[31:0], ip_now[63:32], halted[64], divide_error[65],
  // zero fill up to 72 bits
  output logic [71:0]      m_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready
);

  localparam int unsigned AW = $clog2(MEM_DEPTH);

  state_e      state_q, state_d;
  logic [31:0] rf_q [16];

  // Latched command fields.
  logic [2:0]  func_q, func_d;
  logic [11:0] maddr_q, maddr_d;
  logic [3:0]  ridx_q, ridx_d;
  logic [31:0] wword_q, wword_d;
  logic [30:0] rnd_q, rnd_d;

  // Datapath registers.
  logic [31:0] ir_q, ir_d;
  logic [31:0] a_q, a_d;
  logic [31:0] b_q, b_d;
  logic [31:0] res_a_q, res_a_d;
  logic [31:0] res_b_q, res_b_d;
  logic        has_b_q, has_b_d;
  logic        wr_cc_q, wr_cc_d;
  logic        is_rnd_q, is_rnd_d;
  logic        err_q, err_d;
  logic [31:0] rd_q, rd_d;

  // Output register.
  logic        out_valid_q;
  logic [71:0] out_data_q;
  logic        out_load;

  // Memory port.
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_wdata;
  logic [31:0]   ram_rdata;

  // Register file ports.
  logic [3:0]  rf_raddr;
  logic [31:0] rf_rdata;
  logic        rf_we;
  logic [3:0]  rf_waddr;
  logic [31:0] rf_wdata;
  logic        ip_we, ac_we, cc_we;
  logic [31:0] ip_wdata, ac_wdata, cc_wdata;

  // Divider.
  div_ctrl_t   div_ctrl;
  div_stat_t   div_stat;
  logic [31:0] div_dvd, div_dvs, div_quo, div_rem;

  // Decode of the instruction register.
  logic        is_two, is_stop;
  logic [3:0]  opc;
  logic [1:0]  ta, tb;
  logic [31:0] opa, opb;
  logic [AW-1:0] dir_a, dir_b;
  logic [31:0] val_a, val_b;
  logic [31:0] prod, inc_a, mag_d;
  logic        running, jump;
  logic [31:0] cc_now;

  assign is_two  = (ir_q[31:28] != 4'hF);
  assign is_stop = (ir_q[31:24] == 8'hFF);
  assign opc     = is_two ? ir_q[31:28] : ir_q[27:24];
  assign ta      = is_two ? ir_q[27:26] : ir_q[23:22];
  assign tb      = ir_q[25:24];
  assign opa     = is_two ? {20'd0, ir_q[23:12]} : {16'd0, ir_q[15:0]};
  assign opb     = {20'd0, ir_q[11:0]};
  assign dir_a   = AW'(opa + rf_q[R_DS]);
  assign dir_b   = AW'(opb + rf_q[R_DS]);

  assign rf_rdata = rf_q[rf_raddr];
  assign val_a = (ta == T_REG) ? rd_sector(rf_rdata, opa[5:4]) :
                 (ta == T_DIR) ? ram_rdata : opa;
  assign val_b = (tb == T_REG) ? rd_sector(rf_rdata, opb[5:4]) :
                 (tb == T_DIR) ? ram_rdata : opb;

  assign prod    = a_q * b_q;
  assign inc_a   = a_q + 32'd1;
  assign mag_d   = inc_a[31] ? (32'd0 - inc_a) : inc_a;
  assign running = !rf_q[R_IP][31] && ($signed(rf_q[R_IP]) < $signed(rf_q[R_DS]));
  assign cc_now  = rf_q[R_CC];

  // Jump condition from the condition code.
  always_comb begin
    case (opc)
      OP1_JMP: jump = 1'b1;
      OP1_JZ:  jump = cc_now[0];
      OP1_JP:  jump = (cc_now == 32'd0);
      OP1_JN:  jump = cc_now[31];
      OP1_JNZ: jump = !cc_now[0];
      OP1_JNP: jump = cc_now[31] || (cc_now == 32'd1);
      OP1_JNN: jump = !cc_now[31];
      default: jump = 1'b0;
    endcase
  end

  // Register file read address follows the step that needs it.
  always_comb begin
    case (state_q)
      S_OPA2, S_WBA: rf_raddr = opa[3:0];
      S_OPB2, S_WBB: rf_raddr = opb[3:0];
      default:       rf_raddr = ridx_q;
    endcase
  end

  assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  // Sequencer: next state, datapath loads and write strobes.
  always_comb begin
    state_d   = state_q;
    func_d    = func_q;
    maddr_d   = maddr_q;
    ridx_d    = ridx_q;
    wword_d   = wword_q;
    rnd_d     = rnd_q;
    ir_d      = ir_q;
    a_d       = a_q;
    b_d       = b_q;
    res_a_d   = res_a_q;
    res_b_d   = res_b_q;
    has_b_d   = has_b_q;
    wr_cc_d   = wr_cc_q;
    is_rnd_d  = is_rnd_q;
    err_d     = err_q;
    rd_d      = rd_q;
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = res_a_q;
    rf_we     = 1'b0;
    rf_waddr  = opa[3:0];
    rf_wdata  = wword_q;
    ip_we     = 1'b0;
    ip_wdata  = rf_q[R_DS];
    ac_we     = 1'b0;
    ac_wdata  = div_rem;
    cc_we     = 1'b0;
    cc_wdata  = cc_of(res_a_q);
    div_ctrl.start = 1'b0;
    div_dvd   = a_q;
    div_dvs   = b_q;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          func_d  = s_axis_tdata[2:0];
          maddr_d = s_axis_tdata[14:3];
          ridx_d  = s_axis_tdata[18:15];
          wword_d = s_axis_tdata[50:19];
          rnd_d   = s_axis_tdata[81:51];
          rd_d    = 32'd0;
          err_d   = 1'b0;
          state_d = S_HOST;
        end
      end
      S_HOST: begin
        state_d = S_DONE;
        case (func_q)
          FUNC_WMEM: begin
            ram_we    = 1'b1;
            ram_addr  = AW'(maddr_q);
            ram_wdata = wword_q;
          end
          FUNC_WREG: begin
            rf_we    = 1'b1;
            rf_waddr = ridx_q;
            rf_wdata = wword_q;
          end
          FUNC_RMEM: begin
            ram_addr = AW'(maddr_q);
            state_d  = S_HRD;
          end
          FUNC_RREG: rd_d = rf_rdata;
          FUNC_STEP: begin
            if (running) begin
              ram_addr = AW'(rf_q[R_IP]);
              ip_we    = 1'b1;
              ip_wdata = rf_q[R_IP] + 32'd1;
              state_d  = S_FETCH;
            end
          end
          default: ;
        endcase
      end
      S_HRD: begin
        rd_d    = ram_rdata;
        state_d = S_DONE;
      end
      S_FETCH: begin
        ir_d    = ram_rdata;
        state_d = S_OPA;
      end
      S_OPA: begin
        if (is_stop) begin
          ip_we   = 1'b1;
          state_d = S_DONE;
        end else begin
          ram_addr = dir_a;
          state_d  = S_OPA2;
        end
      end
      S_OPA2: begin
        a_d      = val_a;
        ram_addr = dir_b;
        state_d  = is_two ? S_OPB2 : S_EXEC;
      end
      S_OPB2: begin
        b_d     = ext_b(val_b, tb, opb[5:4]);
        state_d = S_EXEC;
      end
      S_EXEC: begin
        res_a_d  = a_q;
        res_b_d  = b_q;
        has_b_d  = is_two;
        wr_cc_d  = 1'b0;
        is_rnd_d = 1'b0;
        state_d  = S_DONE;
        if (is_two) begin
          wr_cc_d = (opc != OP_MOV) && (opc != OP_SWAP);
          state_d = S_WBA;
          case (opc)
            OP_MOV:  res_a_d = b_q;
            OP_ADD:  res_a_d = a_q + b_q;
            OP_SUB:  res_a_d = a_q - b_q;
            OP_SWAP: begin
              res_a_d = b_q;
              res_b_d = a_q;
            end
            OP_MUL:  res_a_d = prod;
            OP_DIV: begin
              if (b_q == 32'd0) begin
                err_d   = 1'b1;
                state_d = S_DONE;
              end else begin
                div_ctrl.start = 1'b1;
                div_dvd = a_q[31] ? (32'd0 - a_q) : a_q;
                div_dvs = b_q[31] ? (32'd0 - b_q) : b_q;
                state_d = S_DIV;
              end
            end
            OP_CMP: begin
              cc_we    = 1'b1;
              cc_wdata = cc_of(a_q - b_q);
              state_d  = S_DONE;
            end
            OP_SHL:  res_a_d = a_q << b_q[4:0];
            OP_SHR:  res_a_d = 32'($signed(a_q) >>> b_q[4:0]);
            OP_AND:  res_a_d = a_q & b_q;
            OP_OR:   res_a_d = a_q | b_q;
            OP_XOR:  res_a_d = a_q ^ b_q;
            default: state_d = S_DONE;
          endcase
        end else begin
          case (opc)
            OP1_JMP, OP1_JZ, OP1_JP, OP1_JN, OP1_JNZ, OP1_JNP, OP1_JNN: begin
              ip_we    = jump;
              ip_wdata = a_q;
            end
            OP1_LDL: begin
              ac_we    = 1'b1;
              ac_wdata = {rf_q[R_AC][31:16], a_q[15:0]};
            end
            OP1_LDH: begin
              ac_we    = 1'b1;
              ac_wdata = {a_q[15:0], rf_q[R_AC][15:0]};
            end
            OP1_RND: begin
              if (inc_a == 32'd0) begin
                err_d = 1'b1;
              end else begin
                div_ctrl.start = 1'b1;
                div_dvd  = {1'b0, rnd_q};
                div_dvs  = mag_d;
                is_rnd_d = 1'b1;
                state_d  = S_DIV;
              end
            end
            OP1_NOT: begin
              res_a_d = ~a_q;
              wr_cc_d = 1'b1;
              state_d = S_WBA;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          ac_we   = 1'b1;
          state_d = S_WBA;
          if (is_rnd_q) begin
            ac_wdata = div_rem;
          end else begin
            ac_wdata = a_q[31] ? (32'd0 - div_rem) : div_rem;
            res_a_d  = (a_q[31] ^ b_q[31]) ? (32'd0 - div_quo) : div_quo;
          end
        end
      end
      S_WBA: begin
        if (ta == T_REG) begin
          rf_we    = 1'b1;
          rf_waddr = opa[3:0];
          rf_wdata = wr_sector(rf_rdata, res_a_q, opa[5:4]);
        end else if (ta == T_DIR) begin
          ram_we    = 1'b1;
          ram_addr  = dir_a;
          ram_wdata = res_a_q;
        end
        if (has_b_q) begin
          state_d = S_WBB;
        end else begin
          cc_we   = wr_cc_q;
          state_d = S_DONE;
        end
      end
      S_WBB: begin
        if (tb == T_REG) begin
          rf_we    = 1'b1;
          rf_waddr = opb[3:0];
          rf_wdata = wr_sector(rf_rdata, res_b_q, opb[5:4]);
        end else if (tb == T_DIR) begin
          ram_we    = 1'b1;
          ram_addr  = dir_b;
          ram_wdata = res_b_q;
        end
        cc_we   = wr_cc_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Register file; the fixed-role writes come last so that they win.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        rf_q[i] <= 32'd0;
      end
    end else begin
      if (rf_we) begin
        rf_q[rf_waddr] <= rf_wdata;
      end
      if (ip_we) begin
        rf_q[R_IP] <= ip_wdata;
      end
      if (ac_we) begin
        rf_q[R_AC] <= ac_wdata;
      end
      if (cc_we) begin
        rf_q[R_CC] <= cc_wdata;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    maddr_q  <= maddr_d;
    ridx_q   <= ridx_d;
    wword_q  <= wword_d;
    rnd_q    <= rnd_d;
    ir_q     <= ir_d;
    a_q      <= a_d;
    b_q      <= b_d;
    res_a_q  <= res_a_d;
    res_b_q  <= res_b_d;
    has_b_q  <= has_b_d;
    wr_cc_q  <= wr_cc_d;
    is_rnd_q <= is_rnd_d;
    err_q    <= err_d;
    rd_q     <= rd_d;
  end

  // Output register holds the result word until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {6'd0, err_q, !running, rf_q[R_IP], rd_q};
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Main memory.
  rmc_ram #(
    .WIDTH(32),
    .DEPTH(MEM_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // Shared divider for DIV and RND.
  rmc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .stat_o     (div_stat),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  // The divider runs only while the sequencer waits for it.
  `ASSERT_CLK(a_div_busy_in_div, div_stat.busy |-> (state_q == S_DIV), "divider busy outside wait")
  // An accepted command always goes on to its host step.
  `ASSERT_CLK(a_accept_to_host, (s_axis_tvalid && s_axis_tready) |=> (state_q == S_HOST), "bad accept")
  // Memory is written only by host writes and write-back steps.
  `ASSERT_NEVER(a_ram_we_state, ram_we && state_q != S_HOST && state_q != S_WBA && state_q != S_WBB, "stray write")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import rmc_pkg::*;

  localparam int unsigned DEPTH    = 4096;
  localparam int unsigned N_ITEMS  = 750;
  localparam int unsigned WD_LIMIT = 3000;

  // One host command as the sender sees it.
  typedef struct {
    logic [2:0]  func;
    logic [11:0] maddr;
    logic [3:0]  ridx;
    logic [31:0] word;
    logic [30:0] rnd;
    logic        drain;
  } host_cmd_t;

  // One result word as predicted and as received.
  typedef struct {
    logic [31:0] rd;
    logic [31:0] ip;
    logic        halt;
    logic        derr;
  } core_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [87:0] s_data = '0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [71:0] m_data;
  logic        m_valid;
  logic        m_ready = 1'b0;

  register_memory_cpu_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_data),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .m_axis_tdata (m_data),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the core state.
  logic [31:0] core_regs [16];
  logic [31:0] core_mem [DEPTH];

  host_cmd_t cmd_q[$];
  core_res_t result_q[$];
  host_cmd_t cur_cmd;
  logic      cmd_taken = 1'b0;
  int        gap_left = 0;
  int        rcv_wait = 0;
  int        n_sent = 0;
  int        n_words = 0;
  int        n_errors = 0;
  int        n_exec = 0;
  int        n_div_err = 0;
  int        idle_cycles = 0;
  bit        long_hold_done = 1'b0;

  // Operand reads and writes through a register sector or the data segment.
  function automatic logic [31:0] opnd_read(input logic [31:0] op, input logic [1:0] t);
    logic [31:0] r;
    logic [31:0] v;
    logic [31:0] a;
    v = op;
    if (t == T_REG) begin
      r = core_regs[op[3:0]];
      case (op[5:4])
        SEC_WORD: v = r;
        SEC_B0:   v = {24'd0, r[7:0]};
        SEC_B1:   v = {24'd0, r[15:8]};
        default:  v = {16'd0, r[15:0]};
      endcase
    end else if (t == T_DIR) begin
      a = op + core_regs[R_DS];
      v = core_mem[a[11:0]];
    end
    return v;
  endfunction

  function automatic void opnd_write(input logic [31:0] v, input logic [1:0] t,
                                     input logic [31:0] op);
    logic [31:0] r;
    logic [31:0] a;
    if (t == T_REG) begin
      r = core_regs[op[3:0]];
      case (op[5:4])
        SEC_WORD: r = v;
        SEC_B0:   r[7:0] = v[7:0];
        SEC_B1:   r[15:8] = v[7:0];
        default:  r[15:0] = v[15:0];
      endcase
      core_regs[op[3:0]] = r;
    end else if (t == T_DIR) begin
      a = op + core_regs[R_DS];
      core_mem[a[11:0]] = v;
    end
  endfunction

  function automatic void update_cc(input logic [31:0] v);
    core_regs[R_CC] = (v == 32'd0) ? 32'd1 : (v[31] ? SIGN_BIT : 32'd0);
  endfunction

  function automatic logic core_running();
    return !core_regs[R_IP][31] && ($signed(core_regs[R_IP]) < $signed(core_regs[R_DS]));
  endfunction

  // Two-operand instruction; returns the divide error flag.
  function automatic logic exec_dual(input logic [31:0] w);
    logic [3:0]  opc;
    logic [1:0]  t1;
    logic [1:0]  t2;
    logic [31:0] op1;
    logic [31:0] op2;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] tmp;
    logic [31:0] ua;
    logic [31:0] ub;
    logic [31:0] q;
    logic [31:0] rm;
    opc = w[31:28];
    t1  = w[27:26];
    t2  = w[25:24];
    op1 = {20'd0, w[23:12]};
    op2 = {20'd0, w[11:0]};
    a = opnd_read(op1, t1);
    b = opnd_read(op2, t2);
    if (t2 == T_IMM) begin
      b = {{20{b[11]}}, b[11:0]};
    end else if (t2 == T_REG && (op2[5:4] == SEC_B0 || op2[5:4] == SEC_B1)) begin
      b = {{24{b[7]}}, b[7:0]};
    end else if (t2 == T_REG && op2[5:4] == SEC_HALF) begin
      b = {{16{b[15]}}, b[15:0]};
    end
    case (opc)
      OP_MOV:  a = b;
      OP_ADD:  a = a + b;
      OP_SUB:  a = a - b;
      OP_SWAP: begin
        tmp = a;
        a = b;
        b = tmp;
      end
      OP_MUL:  a = a * b;
      OP_DIV: begin
        if (b == 32'd0) return 1'b1;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q  = ua / ub;
        rm = ua % ub;
        if (a[31] ^ b[31]) q = -q;
        if (a[31]) rm = -rm;
        core_regs[R_AC] = rm;
        a = q;
      end
      OP_CMP: begin
        update_cc(a - b);
        return 1'b0;
      end
      OP_SHL:  a = a << b[4:0];
      OP_SHR:  a = $unsigned($signed(a) >>> b[4:0]);
      OP_AND:  a = a & b;
      OP_OR:   a = a | b;
      OP_XOR:  a = a ^ b;
      default: return 1'b0;
    endcase
    opnd_write(a, t1, op1);
    opnd_write(b, t2, op2);
    if (opc != OP_MOV && opc != OP_SWAP) update_cc(a);
    return 1'b0;
  endfunction

  // One-operand instruction; returns the divide error flag.
  function automatic logic exec_single(input logic [31:0] w, input logic [31:0] rnd);
    logic [3:0]  sub;
    logic [1:0]  t;
    logic [31:0] op;
    logic [31:0] v;
    logic [31:0] cc;
    logic [31:0] d;
    sub = w[27:24];
    t   = w[23:22];
    op  = {16'd0, w[15:0]};
    v   = opnd_read(op, t);
    cc  = core_regs[R_CC];
    case (sub)
      OP1_JMP: core_regs[R_IP] = v;
      OP1_JZ:  if (cc[0]) core_regs[R_IP] = v;
      OP1_JP:  if (cc == 32'd0) core_regs[R_IP] = v;
      OP1_JN:  if (cc[31]) core_regs[R_IP] = v;
      OP1_JNZ: if (!cc[0]) core_regs[R_IP] = v;
      OP1_JNP: if (cc[31] || cc == 32'd1) core_regs[R_IP] = v;
      OP1_JNN: if (!cc[31]) core_regs[R_IP] = v;
      OP1_LDL: core_regs[R_AC] = {core_regs[R_AC][31:16], v[15:0]};
      OP1_LDH: core_regs[R_AC] = {v[15:0], core_regs[R_AC][15:0]};
      OP1_RND: begin
        d = v + 32'd1;
        if (d == 32'd0) return 1'b1;
        core_regs[R_AC] = rnd % (d[31] ? -d : d);
        opnd_write(v, t, op);
      end
      OP1_NOT: begin
        v = ~v;
        opnd_write(v, t, op);
        update_cc(v);
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Applies one host command to the shadow state and gives its result word.
  function automatic core_res_t apply_cmd(input host_cmd_t c);
    core_res_t   r;
    logic [31:0] ip;
    logic [31:0] w;
    r.rd   = '0;
    r.derr = 1'b0;
    case (c.func)
      FUNC_WMEM: core_mem[c.maddr] = c.word;
      FUNC_WREG: core_regs[c.ridx] = c.word;
      FUNC_RMEM: r.rd = core_mem[c.maddr];
      FUNC_RREG: r.rd = core_regs[c.ridx];
      FUNC_STEP: begin
        if (core_running()) begin
          n_exec++;
          ip = core_regs[R_IP];
          w  = core_mem[ip[11:0]];
          core_regs[R_IP] = ip + 32'd1;
          if (w[31:28] != 4'hF) begin
            r.derr = exec_dual(w);
          end else if (w[31:24] != 8'hFF) begin
            r.derr = exec_single(w, {1'b0, c.rnd});
          end else begin
            core_regs[R_IP] = core_regs[R_DS];
          end
        end
      end
      default: ;
    endcase
    r.ip   = core_regs[R_IP];
    r.halt = !core_running();
    if (r.derr) n_div_err++;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    $display("ERROR at %0t: word %0d %s got %h, expected %h", $realtime, n_words,
             what, got, want);
  endtask

  task automatic queue_cmd(input logic [2:0] func, input logic [11:0] maddr,
                           input logic [3:0] ridx, input logic [31:0] word,
                           input logic drain);
    host_cmd_t c;
    c.func  = func;
    c.maddr = maddr;
    c.ridx  = ridx;
    c.word  = word;
    c.rnd   = 31'($urandom);
    c.drain = drain;
    cmd_q.push_back(c);
  endtask

  // Random instruction word: mostly two-operand, some one-operand, a few STOPs.
  function automatic logic [31:0] rand_instr();
    int unsigned k;
    logic [3:0]  opc;
    k = $urandom_range(0, 99);
    if (k < 68) begin
      opc = (k < 64) ? 4'($urandom_range(0, 11)) : 4'($urandom_range(12, 14));
      return {opc, 4'($urandom), 24'($urandom)};
    end else if (k < 96) begin
      return {4'hF, 4'($urandom_range(0, 14)), 24'($urandom)};
    end
    return {8'hFF, 24'($urandom)};
  endfunction

  // Reset and stimulus generation.
  initial begin
    logic [31:0] ds;
    int          n_instr;
    for (int i = 0; i < 16; i++) core_regs[i] = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Fill the whole memory so that no instruction ever reads an unset word.
    for (int i = 0; i < DEPTH; i++) begin
      queue_cmd(FUNC_WMEM, 12'(i), '0, $urandom, 1'b0);
    end

    // Directed part: unused codes, extremes and the arithmetic corner cases.
    queue_cmd(3'd5, 12'hFFF, 4'hF, 32'hFFFF_FFFF, 1'b1);
    queue_cmd(3'd6, '0, '0, '0, 1'b0);
    queue_cmd(3'd7, '0, '0, '0, 1'b0);
    queue_cmd(FUNC_STEP, '0, '0, '0, 1'b0);
    queue_cmd(FUNC_RREG, '0, 4'd15, '0, 1'b0);
    queue_cmd(FUNC_WREG, '0, 4'd15, 32'hFFFF_FFFF, 1'b0);
    queue_cmd(FUNC_WREG, '0, 4'd1, SIGN_BIT, 1'b0);
    queue_cmd(FUNC_RMEM, 12'hFFF, '0, '0, 1'b0);
    queue_cmd(FUNC_WMEM, 12'd0, '0, {OP_DIV, T_REG, T_IMM, 12'h001, 12'h000}, 1'b0);
    queue_cmd(FUNC_WMEM, 12'd1, '0, {OP_DIV, T_REG, T_IMM, 12'h001, 12'hFFF}, 1'b0);
    queue_cmd(FUNC_WMEM, 12'd2, '0, {4'hF, OP1_RND, T_REG, 22'h00000F}, 1'b0);
    queue_cmd(FUNC_WMEM, 12'd3, '0, {OP_SHR, T_REG, T_IMM, 12'h00F, 12'h01F}, 1'b0);
    queue_cmd(FUNC_WMEM, 12'd4, '0, {OP_MUL, T_REG, T_REG, 12'h001, 12'h03F}, 1'b0);
    queue_cmd(FUNC_WMEM, 12'd5, '0, {8'hFF, 24'h0}, 1'b0);
    queue_cmd(FUNC_WREG, '0, R_DS, 32'h20, 1'b0);
    queue_cmd(FUNC_WREG, '0, R_IP, 32'h0, 1'b0);
    for (int i = 0; i < 6; i++) queue_cmd(FUNC_STEP, '0, '0, '0, 1'b0);
    queue_cmd(FUNC_RREG, '0, R_AC, '0, 1'b0);
    queue_cmd(FUNC_RREG, '0, 4'd1, '0, 1'b0);

    // Random programs: set the segment, load code, then step through it.
    while (cmd_q.size() < DEPTH + N_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       ds = $urandom_range(0, 1) ? 32'h7FFF_FFFF : SIGN_BIT;
        1:       ds = $urandom;
        default: ds = $urandom_range(8, 64);
      endcase
      queue_cmd(FUNC_WREG, '0, R_DS, ds, $urandom_range(0, 9) == 0);
      queue_cmd(FUNC_WREG, '0, R_IP, $urandom_range(0, 7), 1'b0);
      n_instr = $urandom_range(4, 16);
      for (int i = 0; i < n_instr; i++) begin
        queue_cmd(FUNC_WMEM, 12'(i), '0, rand_instr(), 1'b0);
      end
      for (int i = 0; i < 12; i++) begin
        case ($urandom_range(0, 15))
          0, 1, 2: queue_cmd(FUNC_WREG, '0, R_IP, $urandom_range(0, 15), 1'b0);
          3: queue_cmd(FUNC_RREG, '0, 4'($urandom), '0, 1'b0);
          4: queue_cmd(FUNC_RMEM, 12'($urandom), '0, '0, 1'b0);
          5: queue_cmd(FUNC_WREG, '0, 4'($urandom), $urandom, 1'b0);
          6: queue_cmd(3'($urandom_range(5, 7)), 12'($urandom), 4'($urandom), $urandom, 1'b0);
          default: ;
        endcase
        queue_cmd(FUNC_STEP, '0, '0, '0, 1'b0);
      end
    end

    wait (cmd_q.size() == 0 && !s_valid && result_q.size() == 0);
    repeat (60) @(posedge clk_i);
    $display("Sent %0d commands and checked %0d result words.", n_sent, n_words);
    $display("Executed %0d instructions, %0d of them with a divide error.", n_exec,
             n_div_err);
    if (n_errors == 0 && result_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Sender: presents commands at the falling edge, with random gaps.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_valid || cmd_taken)) begin
      cmd_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        s_valid <= 1'b0;
      end else if (cmd_q.size() > 0 && !(cmd_q[0].drain && result_q.size() > 0)) begin
        cur_cmd = cmd_q.pop_front();
        s_data  <= {6'd0, cur_cmd.rnd, cur_cmd.word, cur_cmd.ridx, cur_cmd.maddr,
                    cur_cmd.func};
        s_valid <= 1'b1;
        gap_left = ((n_sent / 150) % 2 == 1) ? 0 : $urandom_range(0, 4);
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Receiver: ready is lowered for a random number of cycles after each word.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rcv_wait > 0) begin
        rcv_wait--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // Handshake monitor, result check and watchdog.
  always @(posedge clk_i) begin
    core_res_t want;
    logic      moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (s_valid && s_ready && !cmd_taken) begin
        cmd_taken = 1'b1;
        n_sent++;
        moved = 1'b1;
        result_q.push_back(apply_cmd(cur_cmd));
      end
      if (m_valid && m_ready) begin
        moved = 1'b1;
        n_words++;
        if (result_q.size() == 0) begin
          n_errors++;
          $display("ERROR at %0t: result word with nothing expected", $realtime);
        end else begin
          want = result_q.pop_front();
          if (m_data[31:0] !== want.rd) report_mismatch("read_data", m_data[31:0], want.rd);
          if (m_data[63:32] !== want.ip) report_mismatch("ip_now", m_data[63:32], want.ip);
          if (m_data[64] !== want.halt) begin
            report_mismatch("halted", {31'd0, m_data[64]}, {31'd0, want.halt});
          end
          if (m_data[65] !== want.derr) begin
            report_mismatch("divide_error", {31'd0, m_data[65]}, {31'd0, want.derr});
          end
        end
        // Hold off once for a long stretch so that the core backs up.
        if (!long_hold_done && n_words >= DEPTH + 300) begin
          long_hold_done = 1'b1;
          rcv_wait = 80;
        end else begin
          rcv_wait = ((n_words / 200) % 3 == 2) ? 0 : $urandom_range(0, 4);
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", WD_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rmc_pkg.sv
rtl/rmc_ram.sv
rtl/rmc_div.sv
rtl/register_memory_cpu_core.sv
verif/tb.sv
